@@ hw/rtl/srig_pkg.sv @@
// shared types, constants and microprogram for the stepper ramp interval generator
`timescale 1ns / 1ps
`default_nettype none

package srig_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned TICK_SHIFT = 11;
   localparam int unsigned MIN_STEP   = 100;
   localparam int unsigned PC_W       = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned DIV_CNT_W  = $clog2(WORD_W + 1);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CONSTANT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_CAP       = CSR_IDX_W'(2);

   // command codes of a request word
   localparam logic CMD_PULSE = 1'b0;
   localparam logic CMD_START = 1'b1;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD_MOVE,
      OP_ADVANCE,
      OP_ACC_TICK,
      OP_STEP_ACC,
      OP_DEC_TICK,
      OP_STEP_DEC,
      OP_DIV_START,
      OP_LOAD_PERIOD,
      OP_CLEAR
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_CMD,
      COND_CNT_END,
      COND_DECEL,
      COND_NOT_ACC,
      COND_DIV_BUSY,
      COND_PERIOD_ZERO
   } cond_type;

   // kind of response word produced by a step
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_PERIOD,
      EMIT_DONE,
      EMIT_FAULT,
      EMIT_MOVE
   } emit_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      emit_type        emit;
   } ucode_word_type;

   // what the sequencer hands the datapath each cycle
   typedef struct packed {
      op_type   op;
      emit_type emit;
   } exec_type;

   // datapath status seen by the jump logic
   typedef struct packed {
      logic cmd;
      logic cnt_end;
      logic decel;
      logic acc;
      logic div_busy;
      logic period_zero;
   } flags_type;

   // program labels
   localparam logic [PC_W-1:0] L_DISPATCH = PC_W'(0);
   localparam logic [PC_W-1:0] L_DECEL    = PC_W'(7);
   localparam logic [PC_W-1:0] L_DIV      = PC_W'(9);
   localparam logic [PC_W-1:0] L_WAIT     = PC_W'(10);
   localparam logic [PC_W-1:0] L_CHECK    = PC_W'(12);
   localparam logic [PC_W-1:0] L_FAULT    = PC_W'(14);
   localparam logic [PC_W-1:0] L_END      = PC_W'(15);
   localparam logic [PC_W-1:0] L_START    = PC_W'(16);

   // microprogram rom
   function automatic ucode_word_type ucode(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: COND_NEVER, target: L_DISPATCH, emit: EMIT_NONE};
      case (pc)
         5'd0:  w = '{op: OP_NOP,         cond: COND_CMD,         target: L_START,
                     emit: EMIT_NONE};
         5'd1:  w = '{op: OP_ADVANCE,     cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd2:  w = '{op: OP_NOP,         cond: COND_CNT_END,     target: L_END,
                     emit: EMIT_NONE};
         5'd3:  w = '{op: OP_NOP,         cond: COND_DECEL,       target: L_DECEL,
                     emit: EMIT_NONE};
         5'd4:  w = '{op: OP_NOP,         cond: COND_NOT_ACC,     target: L_CHECK,
                     emit: EMIT_NONE};
         5'd5:  w = '{op: OP_ACC_TICK,    cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd6:  w = '{op: OP_STEP_ACC,    cond: COND_ALWAYS,      target: L_DIV,
                     emit: EMIT_NONE};
         5'd7:  w = '{op: OP_DEC_TICK,    cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd8:  w = '{op: OP_STEP_DEC,    cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd9:  w = '{op: OP_DIV_START,   cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd10: w = '{op: OP_NOP,         cond: COND_DIV_BUSY,    target: L_WAIT,
                     emit: EMIT_NONE};
         5'd11: w = '{op: OP_LOAD_PERIOD, cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_NONE};
         5'd12: w = '{op: OP_NOP,         cond: COND_PERIOD_ZERO, target: L_FAULT,
                     emit: EMIT_NONE};
         5'd13: w = '{op: OP_NOP,         cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_PERIOD};
         5'd14: w = '{op: OP_CLEAR,       cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_FAULT};
         5'd15: w = '{op: OP_CLEAR,       cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_DONE};
         5'd16: w = '{op: OP_LOAD_MOVE,   cond: COND_NEVER,       target: L_DISPATCH,
                     emit: EMIT_MOVE};
         default: w = '{op: OP_NOP,       cond: COND_ALWAYS,      target: L_DISPATCH,
                       emit: EMIT_NONE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/srig_divider.sv @@
// restoring radix-2 divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module srig_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [srig_pkg::WORD_W-1:0] dividend,
   input  wire logic [srig_pkg::WORD_W-1:0] divisor,
   output logic                             busy,
   output logic [srig_pkg::WORD_W-1:0]      quotient
);

   logic [srig_pkg::WORD_W-1:0]    rem_ff;
   logic [srig_pkg::WORD_W-1:0]    rem_in;
   logic [srig_pkg::WORD_W-1:0]    quo_ff;
   logic [srig_pkg::WORD_W-1:0]    quo_in;
   logic [srig_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [srig_pkg::DIV_CNT_W-1:0] cnt_in;
   logic                           busy_ff;
   logic                           busy_in;
   logic [srig_pkg::WORD_W:0]      shifted;
   logic [srig_pkg::WORD_W:0]      diff;

   // one shift and trial subtract per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[srig_pkg::WORD_W-1]};
      diff    = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = srig_pkg::DIV_CNT_W'(srig_pkg::WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[srig_pkg::WORD_W]) begin
            rem_in = diff[srig_pkg::WORD_W-1:0];
            quo_in = {quo_ff[srig_pkg::WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[srig_pkg::WORD_W-1:0];
            quo_in = {quo_ff[srig_pkg::WORD_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - srig_pkg::DIV_CNT_W'(1);
         busy_in = (cnt_ff != srig_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/srig_datapath.sv @@
// ramp datapath: move state, csr registers, step clamps and period divider
`timescale 1ns / 1ps
`default_nettype none

module srig_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [srig_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [srig_pkg::WORD_W-1:0]    csr_write_data,
   input  wire logic                           capture,
   input  wire logic                           req_cmd,
   input  wire logic [srig_pkg::WORD_W-1:0]    req_move_length,
   input  wire logic signed [srig_pkg::WORD_W-1:0] req_target_position,
   input  wire logic                           req_direction,
   input  wire srig_pkg::exec_type             exec,
   output srig_pkg::flags_type                 flags,
   output logic [srig_pkg::WORD_W-1:0]         last_period,
   output logic [srig_pkg::WORD_W-1:0]         position
);

   localparam logic [srig_pkg::WORD_W-1:0] MinStep = srig_pkg::WORD_W'(srig_pkg::MIN_STEP);

   // csr registers
   logic [srig_pkg::WORD_W-1:0] speed_constant_ff;
   logic [srig_pkg::WORD_W-1:0] step_limit_ff;
   logic [srig_pkg::WORD_W-1:0] step_cap_ff;

   // captured request word
   logic                        hold_cmd_ff;
   logic [srig_pkg::WORD_W-1:0] hold_length_ff;
   logic [srig_pkg::WORD_W-1:0] hold_target_ff;
   logic                        hold_dir_ff;

   // move state
   logic [srig_pkg::WORD_W-1:0] position_ff,    position_in;
   logic [srig_pkg::WORD_W-1:0] goal_ff,        goal_in;
   logic                        count_up_ff,    count_up_in;
   logic [srig_pkg::WORD_W-1:0] budget_ff,      budget_in;
   logic [srig_pkg::WORD_W-1:0] pulse_count_ff, pulse_count_in;
   logic [srig_pkg::WORD_W-1:0] accel_ff,       accel_in;
   logic [srig_pkg::WORD_W-1:0] step_ff,        step_in;
   logic [srig_pkg::WORD_W-1:0] tick_ff,        tick_in;
   logic [srig_pkg::WORD_W-1:0] period_ff,      period_in;

   logic                        div_busy;
   logic [srig_pkg::WORD_W-1:0] div_quotient;
   logic [srig_pkg::WORD_W:0]   acc_sum;
   logic [srig_pkg::WORD_W:0]   dec_amount;
   logic [srig_pkg::WORD_W:0]   dec_diff;
   logic [srig_pkg::WORD_W:0]   decel_sum;
   logic [srig_pkg::WORD_W-1:0] tick_step;
   logic [srig_pkg::WORD_W-1:0] step_floor;
   logic [srig_pkg::WORD_W-1:0] step_lim;

   // csr writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_constant_ff <= '0;
         step_limit_ff     <= MinStep;
         step_cap_ff       <= MinStep;
      end else if (csr_write_en) begin
         case (csr_index)
            srig_pkg::CSR_SPEED_CONSTANT: speed_constant_ff <= csr_write_data;
            srig_pkg::CSR_STEP_LIMIT:     step_limit_ff     <= csr_write_data;
            srig_pkg::CSR_STEP_CAP:       step_cap_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request capture at accept
   always_ff @(posedge clock) begin
      if (capture) begin
         hold_cmd_ff    <= req_cmd;
         hold_length_ff <= req_move_length;
         hold_target_ff <= req_target_position;
         hold_dir_ff    <= req_direction;
      end
   end

   // shared arithmetic terms
   always_comb begin
      acc_sum    = {1'b0, tick_ff} + {1'b0, period_ff};
      dec_amount = {period_ff, 1'b0};
      dec_diff   = {1'b0, tick_ff} - dec_amount;
      decel_sum  = {1'b0, pulse_count_ff} + {2'b00, accel_ff[srig_pkg::WORD_W-1:1]};
      tick_step  = tick_ff >> srig_pkg::TICK_SHIFT;
      step_floor = (tick_step < MinStep) ? MinStep : tick_step;
      step_lim   = (step_floor >= step_limit_ff) ? step_limit_ff : step_floor;
   end

   // micro-operation execution
   always_comb begin
      position_in    = position_ff;
      goal_in        = goal_ff;
      count_up_in    = count_up_ff;
      budget_in      = budget_ff;
      pulse_count_in = pulse_count_ff;
      accel_in       = accel_ff;
      step_in        = step_ff;
      tick_in        = tick_ff;
      period_in      = period_ff;
      case (exec.op)
         srig_pkg::OP_LOAD_MOVE: begin
            budget_in      = hold_length_ff;
            goal_in        = hold_target_ff;
            count_up_in    = hold_dir_ff;
            pulse_count_in = '0;
            accel_in       = '0;
            step_in        = '0;
            tick_in        = '0;
            period_in      = '0;
         end
         srig_pkg::OP_ADVANCE: begin
            if (goal_ff != position_ff) begin
               position_in = count_up_ff ? position_ff + srig_pkg::WORD_W'(1)
                                         : position_ff - srig_pkg::WORD_W'(1);
            end
            pulse_count_in = pulse_count_ff + srig_pkg::WORD_W'(1);
         end
         srig_pkg::OP_ACC_TICK: begin
            accel_in = accel_ff + srig_pkg::WORD_W'(1);
            tick_in  = acc_sum[srig_pkg::WORD_W] ? '1 : acc_sum[srig_pkg::WORD_W-1:0];
         end
         srig_pkg::OP_STEP_ACC: begin
            step_in = (step_lim > step_cap_ff) ? step_cap_ff : step_lim;
         end
         srig_pkg::OP_DEC_TICK: begin
            if (tick_ff > period_ff) begin
               tick_in = dec_diff[srig_pkg::WORD_W] ? '0 : dec_diff[srig_pkg::WORD_W-1:0];
            end
         end
         srig_pkg::OP_STEP_DEC: begin
            step_in = (step_floor > speed_constant_ff) ? speed_constant_ff : step_floor;
         end
         srig_pkg::OP_LOAD_PERIOD: begin
            period_in = (step_ff == '0) ? '0 : div_quotient;
         end
         srig_pkg::OP_CLEAR: begin
            budget_in      = '0;
            pulse_count_in = '0;
            accel_in       = '0;
            step_in        = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         goal_ff        <= '0;
         count_up_ff    <= 1'b0;
         budget_ff      <= '0;
         pulse_count_ff <= '0;
         accel_ff       <= '0;
         step_ff        <= '0;
         tick_ff        <= '0;
         period_ff      <= '0;
      end else begin
         position_ff    <= position_in;
         goal_ff        <= goal_in;
         count_up_ff    <= count_up_in;
         budget_ff      <= budget_in;
         pulse_count_ff <= pulse_count_in;
         accel_ff       <= accel_in;
         step_ff        <= step_in;
         tick_ff        <= tick_in;
         period_ff      <= period_in;
      end
   end

   // period = speed_constant / step
   srig_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (exec.op == srig_pkg::OP_DIV_START),
      .dividend (speed_constant_ff),
      .divisor  (step_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // status for the jump logic
   always_comb begin
      flags.cmd         = (hold_cmd_ff == srig_pkg::CMD_START);
      flags.cnt_end     = (pulse_count_ff >= budget_ff);
      flags.decel       = (decel_sum >= {1'b0, budget_ff});
      flags.acc         = (step_ff < step_limit_ff);
      flags.div_busy    = div_busy;
      flags.period_zero = (period_ff == '0);
   end

   assign last_period = period_ff;
   assign position    = position_ff;

endmodule

`default_nettype wire

@@ hw/rtl/srig_sequencer.sv @@
// microprogram sequencer: step counter, rom fetch and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module srig_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                emit_ok,
   input  wire srig_pkg::flags_type flags,
   output logic                     busy,
   output srig_pkg::exec_type       exec
);

   logic [srig_pkg::PC_W-1:0] pc_ff;
   logic [srig_pkg::PC_W-1:0] pc_in;
   logic                      busy_ff;
   logic                      busy_in;
   srig_pkg::ucode_word_type  word;
   logic                      stall;
   logic                      active;
   logic                      taken;

   // fetch and stall on a full response slot
   always_comb begin
      word   = srig_pkg::ucode(pc_ff);
      stall  = (word.emit != srig_pkg::EMIT_NONE) && !emit_ok;
      active = busy_ff && !stall;
   end

   // jump condition
   always_comb begin
      case (word.cond)
         srig_pkg::COND_NEVER:       taken = 1'b0;
         srig_pkg::COND_ALWAYS:      taken = 1'b1;
         srig_pkg::COND_CMD:         taken = flags.cmd;
         srig_pkg::COND_CNT_END:     taken = flags.cnt_end;
         srig_pkg::COND_DECEL:       taken = flags.decel;
         srig_pkg::COND_NOT_ACC:     taken = !flags.acc;
         srig_pkg::COND_DIV_BUSY:    taken = flags.div_busy;
         srig_pkg::COND_PERIOD_ZERO: taken = flags.period_zero;
         default:                    taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = srig_pkg::L_DISPATCH;
         busy_in = 1'b1;
      end else if (active) begin
         pc_in = taken ? word.target : pc_ff + srig_pkg::PC_W'(1);
         if (word.emit != srig_pkg::EMIT_NONE) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= srig_pkg::L_DISPATCH;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   // drive the datapath only on live steps
   always_comb begin
      exec.op   = active ? word.op : srig_pkg::OP_NOP;
      exec.emit = active ? word.emit : srig_pkg::EMIT_NONE;
   end

   assign busy = busy_ff;

`ifndef NO_ASSERTIONS
   a_start_dispatch: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && pc_ff == srig_pkg::L_DISPATCH))
      else $error("sequencer did not enter dispatch after start");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("new word started while sequencer busy");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && stall) |=> (busy_ff && pc_ff == $past(pc_ff)))
      else $error("step counter moved during response stall");

   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      (exec.emit != srig_pkg::EMIT_NONE) |-> emit_ok)
      else $error("response emitted into a full slot");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/stepper_ramp_interval_generator.sv @@
// top level of the stepper ramp interval generator: sequencer, datapath, response register
// ramp pulses (accel and decel) wait on the serial divider before their period is emitted;
// start words, end-of-move and cruise pulses do not use it
// flow: one request word at a time; the next can be taken once the response is in the
// output register
// reset: synchronous active high; move state clears, speed_constant 0, limits 100
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_interval_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [srig_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srig_pkg::WORD_W-1:0]        csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic [srig_pkg::WORD_W-1:0]        req_move_length,
   input  wire logic signed [srig_pkg::WORD_W-1:0] req_target_position,
   input  wire logic                               req_direction,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [srig_pkg::WORD_W-1:0]             rsp_period,
   output logic                                    rsp_move_done,
   output logic                                    rsp_fault,
   output logic signed [srig_pkg::WORD_W-1:0]      rsp_current_position
);

   logic                        busy;
   logic                        accept;
   logic                        emit_ok;
   srig_pkg::exec_type          exec;
   srig_pkg::flags_type         flags;
   logic [srig_pkg::WORD_W-1:0] last_period;
   logic [srig_pkg::WORD_W-1:0] position;

   logic                        rsp_valid_ff;
   logic [srig_pkg::WORD_W-1:0] rsp_period_ff;
   logic                        rsp_done_ff;
   logic                        rsp_fault_ff;
   logic [srig_pkg::WORD_W-1:0] rsp_position_ff;

   assign req_ready = !busy;
   assign accept    = req_valid && !busy;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;

   srig_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .emit_ok (emit_ok),
      .flags   (flags),
      .busy    (busy),
      .exec    (exec)
   );

   srig_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .capture             (accept),
      .req_cmd             (req_cmd),
      .req_move_length     (req_move_length),
      .req_target_position (req_target_position),
      .req_direction       (req_direction),
      .exec                (exec),
      .flags               (flags),
      .last_period         (last_period),
      .position            (position)
   );

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec.emit != srig_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec.emit != srig_pkg::EMIT_NONE) begin
         rsp_period_ff   <= (exec.emit == srig_pkg::EMIT_PERIOD) ? last_period : '0;
         rsp_done_ff     <= (exec.emit == srig_pkg::EMIT_DONE);
         rsp_fault_ff    <= (exec.emit == srig_pkg::EMIT_FAULT);
         rsp_position_ff <= position;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_period           = rsp_period_ff;
   assign rsp_move_done        = rsp_done_ff;
   assign rsp_fault            = rsp_fault_ff;
   assign rsp_current_position = rsp_position_ff;

endmodule

`default_nettype wire

@@ test/tb_stepper_ramp_interval_generator.sv @@
// self-checking testbench for the stepper ramp interval generator
`timescale 1ns / 1ps

module tb_stepper_ramp_interval_generator;

   localparam int unsigned RAMP_SHIFT      = 11;
   localparam logic [31:0] STEP_FLOOR      = 32'd100;
   localparam int          WATCHDOG_LIMIT  = 4000;
   localparam int          RSP_HOLD_CYCLES = 400;
   localparam int          ITEM_GOAL       = 1750;
   localparam int          DIRECTED_WORDS  = 25;
   localparam int          SEGMENTS        = 6;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          DRAIN_CYCLES    = 60;

   // one response word as the block should produce it
   typedef struct {
      logic [31:0] period;
      logic        move_done;
      logic        fault;
      logic [31:0] position;
   } interval_word_type;

   // ramp predictor plus the queue of interval words still owed by the block
   class ramp_scoreboard;
      logic [31:0] speed_constant, step_limit, step_cap;
      logic [31:0] position, goal, budget, pulses, accel_pulses;
      logic [31:0] step_value, tick_sum, last_period;
      logic        count_up;
      interval_word_type due_words[$];
      int errors;

      function new();
         speed_constant = '0;
         step_limit     = 32'd100;
         step_cap       = 32'd100;
         position       = '0;
         goal           = '0;
         count_up       = 1'b0;
         tick_sum       = '0;
         last_period    = '0;
         errors         = 0;
         clear_counters();
      endfunction

      function void clear_counters();
         budget       = '0;
         pulses       = '0;
         accel_pulses = '0;
         step_value   = '0;
      endfunction

      function logic [31:0] divide_step(logic [31:0] step);
         return (step == '0) ? '0 : speed_constant / step;
      endfunction

      function void write_register(logic [srig_pkg::CSR_IDX_W-1:0] index,
                                   logic [31:0] value);
         case (index)
            srig_pkg::CSR_SPEED_CONSTANT: speed_constant = value;
            srig_pkg::CSR_STEP_LIMIT:     step_limit = value;
            srig_pkg::CSR_STEP_CAP:       step_cap = value;
            default: ;
         endcase
      endfunction

      // advance the ramp by one accepted request word and queue its response
      function void note_word(logic cmd, logic [31:0] length, logic [31:0] target,
                              logic dir);
         interval_word_type w;
         logic [32:0] wide;
         w.period    = '0;
         w.move_done = 1'b0;
         w.fault     = 1'b0;
         if (cmd == srig_pkg::CMD_START) begin
            budget       = length;
            goal         = target;
            count_up     = dir;
            pulses       = '0;
            accel_pulses = '0;
            step_value   = '0;
            tick_sum     = '0;
            last_period  = '0;
         end else begin
            if (goal != position)
               position = count_up ? position + 32'd1 : position - 32'd1;
            pulses = pulses + 32'd1;
            if (pulses >= budget) begin
               // end of move
               clear_counters();
               w.move_done = 1'b1;
            end else begin
               if ({1'b0, pulses} + {2'b0, accel_pulses[31:1]} >= {1'b0, budget}) begin
                  // deceleration: tick sum drops by twice the period, floored at zero
                  if (tick_sum > last_period) begin
                     wide = {last_period, 1'b0};
                     tick_sum = ({1'b0, tick_sum} >= wide) ? tick_sum - wide[31:0] : '0;
                  end
                  step_value = tick_sum >> RAMP_SHIFT;
                  if (step_value < STEP_FLOOR) step_value = STEP_FLOOR;
                  if (step_value > speed_constant) step_value = speed_constant;
                  last_period = divide_step(step_value);
               end else if (step_value < step_limit) begin
                  // acceleration: tick sum grows by the period, saturating
                  wide = {1'b0, tick_sum} + {1'b0, last_period};
                  accel_pulses = accel_pulses + 32'd1;
                  tick_sum = wide[32] ? '1 : wide[31:0];
                  step_value = tick_sum >> RAMP_SHIFT;
                  if (step_value < STEP_FLOOR) step_value = STEP_FLOOR;
                  if (step_value >= step_limit) step_value = step_limit;
                  if (step_value > step_cap) step_value = step_cap;
                  last_period = divide_step(step_value);
               end
               // zero period aborts the move
               if (last_period == '0) begin
                  clear_counters();
                  w.fault = 1'b1;
               end else begin
                  w.period = last_period;
               end
            end
         end
         w.position = position;
         due_words.push_back(w);
      endfunction

      // compare one accepted response word with the oldest owed one
      function void check_word(logic [31:0] period, logic done, logic fault,
                               logic [31:0] pos);
         interval_word_type w;
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word: period %0d done %0b fault %0b position %0d",
                     $time, period, done, fault, $signed(pos));
            errors++;
            return;
         end
         w = due_words.pop_front();
         if (period !== w.period) begin
            $display("%0t: period expected %0d actual %0d", $time, w.period, period);
            errors++;
         end
         if (done !== w.move_done) begin
            $display("%0t: move_done expected %0b actual %0b", $time, w.move_done, done);
            errors++;
         end
         if (fault !== w.fault) begin
            $display("%0t: fault expected %0b actual %0b", $time, w.fault, fault);
            errors++;
         end
         if (pos !== w.position) begin
            $display("%0t: current_position expected %0d actual %0d", $time,
                     $signed(w.position), $signed(pos));
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           csr_write_en;
   logic [srig_pkg::CSR_IDX_W-1:0] csr_index;
   logic [srig_pkg::WORD_W-1:0]    csr_write_data;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_cmd;
   logic [srig_pkg::WORD_W-1:0]    req_move_length;
   logic signed [srig_pkg::WORD_W-1:0] req_target_position;
   logic                           req_direction;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [srig_pkg::WORD_W-1:0]    rsp_period;
   logic                           rsp_move_done;
   logic                           rsp_fault;
   logic signed [srig_pkg::WORD_W-1:0] rsp_current_position;

   ramp_scoreboard book;
   int send_idle_pct;
   int recv_idle_pct;
   logic stall_rsp;
   int words_sent;
   int quiet_cycles = 0;

   stepper_ramp_interval_generator uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_move_length      (req_move_length),
      .req_target_position  (req_target_position),
      .req_direction        (req_direction),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_period           (rsp_period),
      .rsp_move_done        (rsp_move_done),
      .rsp_fault            (rsp_fault),
      .rsp_current_position (rsp_current_position)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // offer one request word, hold it until accepted; entered and left at a falling edge
   task automatic send_word(input logic cmd, input logic [31:0] length,
                            input logic [31:0] target, input logic dir);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd             = cmd;
      req_move_length     = length;
      req_target_position = target;
      req_direction       = dir;
      req_valid           = 1'b1;
      do @(posedge clock); while (!req_ready);
      book.note_word(cmd, length, target, dir);
      words_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [srig_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] value);
      csr_write_en   = 1'b1;
      csr_index      = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      book.write_register(index, value);
   endtask

   // registers change only once every owed word is back and the block has settled
   task automatic load_settings(input logic [31:0] sc, input logic [31:0] lim,
                                input logic [31:0] cap);
      while (book.due_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(srig_pkg::CSR_SPEED_CONSTANT, sc);
      write_csr(srig_pkg::CSR_STEP_LIMIT, lim);
      write_csr(srig_pkg::CSR_STEP_CAP, cap);
   endtask

   // one start word and its pulses, mostly well formed, sometimes cut short or noise
   task automatic run_move();
      int kind;
      int count;
      logic [31:0] length;
      logic [31:0] target;
      logic dir;
      kind = $urandom_range(99);
      if (kind >= 90) begin
         send_word(1'($urandom_range(1)), $urandom, $urandom, 1'($urandom_range(1)));
         return;
      end
      dir = 1'($urandom_range(1));
      if (kind >= 80) begin
         // long move abandoned early, stays in the ramp
         length = $urandom;
         count  = $urandom_range(4, 20);
      end else begin
         length = $urandom_range(1, 40);
         count  = length + $urandom_range(0, 2);
         if ($urandom_range(9) == 0) count = $urandom_range(0, length);
      end
      case ($urandom_range(3))
         0: target = book.position;
         1: target = dir ? book.position + length : book.position - length;
         2: target = dir ? book.position + $urandom_range(20)
                         : book.position - $urandom_range(20);
         default: target = $urandom;
      endcase
      send_word(srig_pkg::CMD_START, length, target, dir);
      repeat (count)
         send_word(srig_pkg::CMD_PULSE, $urandom, $urandom, 1'($urandom_range(1)));
   endtask

   // receiver: random ready, with one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_rsp) begin
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            stall_rsp = 1'b0;
         end
         rsp_ready = !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_word(rsp_period, rsp_move_done, rsp_fault, rsp_current_position);
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("stepper_ramp_interval_generator test failed");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      logic [31:0] sc, lim, cap;
      int seg_end;
      book                = new();
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_valid           = 1'b0;
      req_cmd             = srig_pkg::CMD_PULSE;
      req_move_length     = '0;
      req_target_position = '0;
      req_direction       = 1'b0;
      send_idle_pct       = 20;
      recv_idle_pct       = 62;
      stall_rsp           = 1'b0;
      words_sent          = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset registers leave a zero speed constant, so a ramp pulse faults
      send_word(srig_pkg::CMD_PULSE, '0, '0, 1'b0);    // pulse with no move, position at goal
      send_word(srig_pkg::CMD_START, 32'd3, '0, 1'b0); // goal equals position
      send_word(srig_pkg::CMD_PULSE, '1, '1, 1'b1);    // zero period aborts
      send_word(srig_pkg::CMD_PULSE, '0, '0, 1'b0);
      load_settings(32'd2_000_000, 32'd400, 32'd300);
      // counts down through zero; ramps up, decelerates, ends
      send_word(srig_pkg::CMD_START, 32'd14, -32'sd6, 1'b0);
      repeat (14)
         send_word(srig_pkg::CMD_PULSE, $urandom, $urandom, 1'($urandom_range(1)));
      // extreme length and targets
      send_word(srig_pkg::CMD_START, '1, 32'h7FFF_FFFF, 1'b1);
      repeat (3) send_word(srig_pkg::CMD_PULSE, '0, '0, 1'b0);
      send_word(srig_pkg::CMD_START, '0, 32'h8000_0000, 1'b0);
      send_word(srig_pkg::CMD_PULSE, '1, '1, 1'b1);    // zero-length move ends at once

      // random segments, each under its own register setting
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin
               sc = '1; lim = '1; cap = '1;
            end
            1: begin
               sc = 32'd3_000_000; lim = 32'd100; cap = 32'd100;
            end
            2: begin
               sc  = $urandom_range(1_000_000, 40_000_000);
               lim = $urandom_range(100, 2000);
               cap = $urandom_range(100, 2000);
            end
            3: begin
               sc  = $urandom;
               lim = $urandom_range(32'hFFFF_FFFF, 100);
               cap = $urandom_range(32'hFFFF_FFFF, 100);
            end
            4: begin
               sc  = $urandom_range(0, 300);
               lim = $urandom_range(100, 300);
               cap = $urandom_range(100, 300);
            end
            default: begin
               sc  = $urandom_range(200_000, 10_000_000);
               lim = $urandom_range(100, 1000);
               cap = '1;
            end
         endcase
         load_settings(sc, lim, cap);
         if (seg == 2) begin
            send_idle_pct = 62;
            recv_idle_pct = 20;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            stall_rsp     = 1'b1;
         end
         seg_end = DIRECTED_WORDS + (seg + 1) * ((ITEM_GOAL - DIRECTED_WORDS) / SEGMENTS);
         while (words_sent < seg_end) run_move();
      end

      // drain
      while (book.due_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (book.errors == 0)
         $display("stepper_ramp_interval_generator test passed");
      else
         $display("stepper_ramp_interval_generator test failed");
      $finish;
   end

endmodule
